// File: design/pmst_pkg.sv
// Shared types and constants for the Prim spanning tree core.
// Item structs, request and status codes, and the sequencer state type.
// No dependencies.
package pmst_pkg;

	// Parameter defaults
	localparam int DEF_MAX_VERTICES = 16;
	localparam int DEF_WEIGHT_BITS  = 16;

	// Fixed field widths of the item beats
	localparam int VERTEX_BITS  = 4;
	localparam int EDGE_BITS    = 16;
	localparam int SUM_BITS     = 20;
	localparam int CFG_BITS     = 5;

	localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(16);
	localparam logic [SUM_BITS-1:0] SUM_MAX   = '1;

	// Request and status codes
	localparam logic REQ_LOAD            = 1'b0;
	localparam logic REQ_START           = 1'b1;
	localparam logic STATUS_EDGE         = 1'b0;
	localparam logic STATUS_DISCONNECTED = 1'b1;

	typedef struct packed {
		logic                   req_type;
		logic [VERTEX_BITS-1:0] vertex_a;
		logic [VERTEX_BITS-1:0] vertex_b;
		logic [EDGE_BITS-1:0]   edge_weight;
	} pmst_req_t;

	typedef struct packed {
		logic [VERTEX_BITS-1:0] tree_parent;
		logic [VERTEX_BITS-1:0] tree_vertex;
		logic [EDGE_BITS-1:0]   tree_edge_weight;
		logic [SUM_BITS-1:0]    total_weight;
		logic                   status;
		logic                   last;
	} pmst_rsp_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} pmst_state_t;

endpackage

// File: design/pmst_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the adjacency matrix and the per-vertex best-edge table.
// No package dependencies.
module pmst_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/pmst_seq.sv
// Run sequencer: matrix clearing pass, edge loads, relax and minimum scan, result beats.
// Depends on pmst_pkg; drives the ports of two pmst_ram instances in the top level.
module pmst_seq import pmst_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS,
	localparam int VW = $clog2(MAX_VERTICES),
	localparam int CW = $clog2(MAX_VERTICES + 1),
	localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES),
	localparam int BW = WEIGHT_BITS + VW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [CW-1:0]          n_eff,
	input  pmst_req_t              req,
	input  logic                   req_take,
	output logic                   idle,
	output logic                   res_valid,
	output pmst_rsp_t              res,
	input  logic                   res_ready,
	output logic                   adj_we,
	output logic [AW-1:0]          adj_waddr,
	output logic [WEIGHT_BITS-1:0] adj_wdata,
	output logic [AW-1:0]          adj_raddr,
	input  logic [WEIGHT_BITS-1:0] adj_rdata,
	output logic                   best_we,
	output logic [VW-1:0]          best_waddr,
	output logic [BW-1:0]          best_wdata,
	output logic [VW-1:0]          best_raddr,
	input  logic [BW-1:0]          best_rdata
);

	localparam int SW = ((WEIGHT_BITS > SUM_BITS) ? WEIGHT_BITS : SUM_BITS) + 1;
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_VERTICES * MAX_VERTICES - 1);

	// Symmetric matrix: keep only the cell with the lower index as row
	function automatic logic [AW-1:0] cell_addr(input logic [VW-1:0] x,
		input logic [VW-1:0] y);
		logic [VW-1:0] lo;
		logic [VW-1:0] hi;
		lo = (x < y) ? x : y;
		hi = (x < y) ? y : x;
		return AW'(lo) * AW'(MAX_VERTICES) + AW'(hi);
	endfunction

	pmst_state_t state_q, state_d;

	logic [AW-1:0]           clr_q;
	logic [CW-1:0]           n_q;
	logic [VW-1:0]           cur_q;
	logic [CW-1:0]           step_q;
	logic [CW-1:0]           idx_q;
	logic [MAX_VERTICES-1:0] in_tree_q;
	logic [MAX_VERTICES-1:0] valid_q;
	logic [SUM_BITS-1:0]     sum_q;
	logic                    vld_s1;
	logic [VW-1:0]           idx_s1;
	logic                    found_q;
	logic [WEIGHT_BITS-1:0]  minw_q;
	logic [VW-1:0]           minp_q;
	logic [VW-1:0]           sel_q;

	logic                   load_ok, start, issue, scan_done, final_step;
	logic                   outside, upd, cand, better;
	logic [WEIGHT_BITS-1:0] best_w, new_w;
	logic [VW-1:0]          best_p, new_p;
	logic [SW-1:0]          sum_ext;
	logic [SUM_BITS-1:0]    sum_new;

	// Decode the accepted beat
	assign load_ok = req_take && (req.req_type == REQ_LOAD)
		&& (int'(req.vertex_a) < MAX_VERTICES) && (int'(req.vertex_b) < MAX_VERTICES);
	assign start   = req_take && (req.req_type == REQ_START);

	// Read issue for the scan of the current vertex row
	assign issue      = (state_q == ST_SCAN) && (idx_q < n_q);
	assign adj_raddr  = cell_addr(cur_q, idx_q[VW-1:0]);
	assign best_raddr = idx_q[VW-1:0];

	// Relax the entry returned by the memories and fold it into the minimum
	assign {best_w, best_p} = best_rdata;
	assign outside = !in_tree_q[idx_s1];
	assign upd     = vld_s1 && (adj_rdata != '0) && outside
		&& (!valid_q[idx_s1] || (adj_rdata < best_w));
	assign new_w   = upd ? adj_rdata : best_w;
	assign new_p   = upd ? cur_q : best_p;
	assign cand    = vld_s1 && outside && (valid_q[idx_s1] || upd);
	assign better  = cand && (!found_q || (new_w < minw_q));
	assign scan_done = vld_s1 && (CW'(idx_s1) == n_q - CW'(1));

	assign best_we    = upd;
	assign best_waddr = idx_s1;
	assign best_wdata = {adj_rdata, cur_q};

	// Matrix write: clearing pass or edge load
	assign adj_we    = (state_q == ST_CLEAR) || load_ok;
	assign adj_waddr = (state_q == ST_CLEAR) ? clr_q
		: cell_addr(VW'(req.vertex_a), VW'(req.vertex_b));
	assign adj_wdata = (state_q == ST_CLEAR) ? '0 : WEIGHT_BITS'(req.edge_weight);

	// Saturating running total
	assign sum_ext    = SW'(sum_q) + SW'(minw_q);
	assign sum_new    = (sum_ext > SW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_BITS-1:0];
	assign final_step = (step_q == n_q - CW'(1));

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and result beat
	always_comb begin
		state_d   = state_q;
		idle      = 1'b0;
		res_valid = 1'b0;
		if (found_q) begin
			res.tree_parent      = VERTEX_BITS'(minp_q);
			res.tree_vertex      = VERTEX_BITS'(sel_q);
			res.tree_edge_weight = EDGE_BITS'(minw_q);
			res.total_weight     = sum_new;
			res.status           = STATUS_EDGE;
			res.last             = final_step;
		end else begin
			res.tree_parent      = '0;
			res.tree_vertex      = '0;
			res.tree_edge_weight = '0;
			res.total_weight     = sum_q;
			res.status           = STATUS_DISCONNECTED;
			res.last             = 1'b1;
		end
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				idle = 1'b1;
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = (!found_q || final_step) ? ST_IDLE : ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Run control and scan pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			n_q       <= '0;
			cur_q     <= '0;
			step_q    <= '0;
			idx_q     <= '0;
			in_tree_q <= '0;
			valid_q   <= '0;
			sum_q     <= '0;
			vld_s1    <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			vld_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			// Seed the tree with vertex zero
			if (start) begin
				n_q       <= n_eff;
				cur_q     <= '0;
				step_q    <= CW'(1);
				idx_q     <= '0;
				in_tree_q <= {{(MAX_VERTICES-1){1'b0}}, 1'b1};
				valid_q   <= '0;
				sum_q     <= '0;
				found_q   <= 1'b0;
			end
			if (upd) begin
				valid_q[idx_s1] <= 1'b1;
			end
			if (better) begin
				found_q <= 1'b1;
			end
			// Advance to the newly added vertex
			if ((state_q == ST_EMIT) && res_ready && found_q) begin
				in_tree_q[sel_q] <= 1'b1;
				cur_q            <= sel_q;
				sum_q            <= sum_new;
				step_q           <= step_q + CW'(1);
				idx_q            <= '0;
				found_q          <= 1'b0;
			end
		end
	end

	// Minimum candidate payload
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[VW-1:0];
		if (better) begin
			minw_q <= new_w;
			minp_q <= new_p;
			sel_q  <= idx_s1;
		end
	end

endmodule

// File: design/prim_minimum_spanning_tree_core.sv
// Prim spanning tree core. A load beat may follow every cycle while the sequencer is idle.
// A start beat runs n-1 steps; each step reads the row of the newest vertex through
// the adjacency RAM pipeline, and a run holds the input until its last result is taken.
// Results leave through an output register.
// After reset a clearing pass zeroes the matrix with req_stall high;
// vertex_count resets to 16 and configuration writes are taken at any time.
module prim_minimum_spanning_tree_core import pmst_pkg::*; #(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  pmst_req_t           req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pmst_rsp_t           rsp,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_BITS-1:0] cfg_data
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
	localparam int BW = WEIGHT_BITS + VW;

	logic [CFG_BITS-1:0]    cfg_q;
	logic [CW-1:0]          n_eff;
	logic                   req_take, seq_idle;
	logic                   res_valid, res_ready;
	pmst_rsp_t              res;
	pmst_rsp_t              out_q;
	logic                   out_valid_q;
	logic                   adj_we, best_we;
	logic [AW-1:0]          adj_waddr, adj_raddr;
	logic [WEIGHT_BITS-1:0] adj_wdata, adj_rdata;
	logic [VW-1:0]          best_waddr, best_raddr;
	logic [BW-1:0]          best_wdata, best_rdata;

	// Vertex count register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= cfg_data;
		end
	end

	// Clamp the vertex count to the supported range
	always_comb begin
		if (int'(cfg_q) < 2) begin
			n_eff = CW'(2);
		end else if (int'(cfg_q) > MAX_VERTICES) begin
			n_eff = CW'(MAX_VERTICES);
		end else begin
			n_eff = CW'(cfg_q);
		end
	end

	// Input handshake: beats are taken only while the sequencer is idle
	assign req_stall = !seq_idle;
	assign req_take  = req_valid && !req_stall;

	pmst_seq #(
		.MAX_VERTICES(MAX_VERTICES),
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.n_eff     (n_eff),
		.req       (req),
		.req_take  (req_take),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.adj_we    (adj_we),
		.adj_waddr (adj_waddr),
		.adj_wdata (adj_wdata),
		.adj_raddr (adj_raddr),
		.adj_rdata (adj_rdata),
		.best_we   (best_we),
		.best_waddr(best_waddr),
		.best_wdata(best_wdata),
		.best_raddr(best_raddr),
		.best_rdata(best_rdata)
	);

	pmst_ram #(
		.DEPTH(MAX_VERTICES * MAX_VERTICES),
		.WIDTH(WEIGHT_BITS)
	) u_adj_ram (
		.clk  (clk),
		.we   (adj_we),
		.waddr(adj_waddr),
		.wdata(adj_wdata),
		.raddr(adj_raddr),
		.rdata(adj_rdata)
	);

	pmst_ram #(
		.DEPTH(MAX_VERTICES),
		.WIDTH(BW)
	) u_best_ram (
		.clk  (clk),
		.we   (best_we),
		.waddr(best_waddr),
		.wdata(best_wdata),
		.raddr(best_raddr),
		.rdata(best_rdata)
	);

	// Output register: load a new beat when empty or draining
	assign res_ready = !out_valid_q || !rsp_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// A disconnected status always ends the run
	a_disc_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_DISCONNECTED) |-> rsp.last)
		else $error("disconnected result without last");

	// A tree edge never carries the no-edge weight
	a_edge_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STATUS_EDGE) |-> (rsp.tree_edge_weight != '0))
		else $error("tree edge with zero weight");

	// While a run still owes results, no new request is taken
	a_run_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> req_stall)
		else $error("request taken in the middle of a run");

endmodule
